// ===== rtl/core/u16u8_pkg.sv =====
// Package for the UTF-16 to UTF-8 transcoder: status codes, surrogate tags
// and the queue entry that the front end hands to the byte serializer.
// Depends on nothing.
package u16u8_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [15:0] SURROGATE_MASK = 16'hfc00;
   localparam logic [15:0] LEAD_TAG       = 16'hd800;
   localparam logic [15:0] TRAIL_TAG      = 16'hdc00;
   localparam logic [20:0] PLANE1_BASE    = 21'h10000;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_TRAIL = 2'd1,
      STATUS_NO_LEAD  = 2'd2
   } status_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_index;
      logic            string_done;
      status_type      status;
   } entry_type;

endpackage

// ===== rtl/core/u16u8_if.sv =====
// Channel interfaces of the transcoder: one for code units in, one for
// UTF-8 bytes out. Both use a valid/ready handshake. Depends on u16u8_pkg.
interface u16u8_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        end_of_string;

   modport source (output valid, output code_unit, output end_of_string, input ready);
   modport sink (input valid, input code_unit, input end_of_string, output ready);
endinterface

interface u16u8_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [7:0]             out_byte;
   logic                   run_last;
   logic                   string_done;
   u16u8_pkg::status_type  status;

   modport source (output valid, output out_byte, output run_last, output string_done,
                   output status, input ready);
   modport sink (input valid, input out_byte, input run_last, input string_done,
                 input status, output ready);
endinterface

// ===== rtl/core/utf16_to_utf8_transcoder.sv =====
// UTF-16 to UTF-8 transcoder, top level.
// The req_if channel takes one UTF-16 code unit per item with an end of
// string flag. The rsp_if channel gives one UTF-8 byte per item; run_last
// marks the final byte caused by one code unit, and status reports a lead
// surrogate without its trail or a trail without its lead as a single zero
// byte. A lead surrogate that does not end the string gives no output until
// the next unit; a trail then makes the pair give four bytes, any other unit
// a no-trail zero byte. The first byte of a code unit passes through the
// queue and then the output register. Throughput: one byte per cycle on
// rsp_if while rsp_if.ready is high; a code unit gives one to three bytes and
// a surrogate pair four. The rate is set by the single byte lane of the
// serializer. A queue of QueueDepth encoded entries lets the input side run
// ahead while bytes are still going out, and code units are accepted while
// the queue has room. A synchronous reset empties the queue, drops the output
// byte and any waiting lead surrogate. When the receiver holds rsp_if.ready
// low the output byte holds, the queue fills and req_if.ready then falls.
// Depends on u16u8_pkg, u16u8_if, u16u8_front, u16u8_queue, u16u8_back.
module utf16_to_utf8_transcoder #(
   parameter int QueueDepth = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   u16u8_req_if.sink    req_if,
   u16u8_rsp_if.source  rsp_if
);

   logic                 push_valid, push_ready;
   logic                 pop_valid, pop_ready;
   u16u8_pkg::entry_type push_entry, pop_entry;

   u16u8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   u16u8_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   u16u8_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_if    (rsp_if)
   );

endmodule

// ===== rtl/core/u16u8_front.sv =====
// Front end of the transcoder: accepts code units, pairs surrogates and
// encodes each code point into a queue entry. Depends on u16u8_pkg, u16u8_if.
module u16u8_front (
   input  logic                 clock,
   input  logic                 reset,
   u16u8_req_if.sink            req_if,
   output logic                 push_valid,
   input  logic                 push_ready,
   output u16u8_pkg::entry_type push_entry
);

   logic       lead_pending_ff, lead_pending_in;
   logic [9:0] lead_bits_ff, lead_bits_in;
   logic       accept;
   logic       is_lead;
   logic       is_trail;
   logic       store_only;
   logic [20:0] pair_cp;

   function automatic u16u8_pkg::entry_type encode(input logic [20:0] cp, input logic done);
      u16u8_pkg::entry_type e;
      e = '0;
      e.string_done = done;
      e.status = u16u8_pkg::STATUS_OK;
      if (cp < 21'h80) begin
         e.bytes[0] = cp[7:0];
         e.last_index = 2'd0;
      end else if (cp < 21'h800) begin
         e.bytes[0] = {3'b110, cp[10:6]};
         e.bytes[1] = {2'b10, cp[5:0]};
         e.last_index = 2'd1;
      end else if (cp < 21'h10000) begin
         e.bytes[0] = {4'b1110, cp[15:12]};
         e.bytes[1] = {2'b10, cp[11:6]};
         e.bytes[2] = {2'b10, cp[5:0]};
         e.last_index = 2'd2;
      end else begin
         e.bytes[0] = {5'b11110, cp[20:18]};
         e.bytes[1] = {2'b10, cp[17:12]};
         e.bytes[2] = {2'b10, cp[11:6]};
         e.bytes[3] = {2'b10, cp[5:0]};
         e.last_index = 2'd3;
      end
      return e;
   endfunction

   function automatic u16u8_pkg::entry_type error_entry(input logic done,
                                                        input u16u8_pkg::status_type st);
      u16u8_pkg::entry_type e;
      e = '0;
      e.string_done = done;
      e.status = st;
      return e;
   endfunction

   assign req_if.ready = push_ready;
   assign accept = req_if.valid && push_ready;
   assign is_lead = (req_if.code_unit & u16u8_pkg::SURROGATE_MASK) == u16u8_pkg::LEAD_TAG;
   assign is_trail = (req_if.code_unit & u16u8_pkg::SURROGATE_MASK) == u16u8_pkg::TRAIL_TAG;
   assign pair_cp = u16u8_pkg::PLANE1_BASE + {1'b0, lead_bits_ff, req_if.code_unit[9:0]};

   always_comb begin
      store_only = 1'b0;
      lead_pending_in = lead_pending_ff;
      lead_bits_in = lead_bits_ff;
      push_entry = encode({5'd0, req_if.code_unit}, req_if.end_of_string);
      if (lead_pending_ff) begin
         lead_pending_in = 1'b0;
         lead_bits_in = '0;
         if (!is_trail) begin
            push_entry = error_entry(req_if.end_of_string, u16u8_pkg::STATUS_NO_TRAIL);
         end else begin
            push_entry = encode(pair_cp, req_if.end_of_string);
         end
      end else if (is_lead) begin
         if (req_if.end_of_string) begin
            push_entry = error_entry(req_if.end_of_string, u16u8_pkg::STATUS_NO_TRAIL);
         end else begin
            store_only = 1'b1;
            lead_pending_in = 1'b1;
            lead_bits_in = req_if.code_unit[9:0];
         end
      end else if (is_trail) begin
         push_entry = error_entry(req_if.end_of_string, u16u8_pkg::STATUS_NO_LEAD);
      end
   end

   assign push_valid = accept && !store_only;

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_pending_ff <= 1'b0;
         lead_bits_ff <= '0;
      end else if (accept) begin
         lead_pending_ff <= lead_pending_in;
         lead_bits_ff <= lead_bits_in;
      end
   end

endmodule

// ===== rtl/core/u16u8_queue.sv =====
// Short queue of encoded entries between the front end and the serializer.
// The head entry is shown ahead of the pop. Depends on u16u8_pkg.
module u16u8_queue #(
   parameter int Depth = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  u16u8_pkg::entry_type push_entry,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output u16u8_pkg::entry_type pop_entry
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   u16u8_pkg::entry_type store_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CountWidth-1:0] count_ff;
   logic                  do_push, do_pop;

   assign push_ready = count_ff != CountWidth'(Depth);
   assign pop_valid = count_ff != '0;
   assign pop_entry = store_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/core/u16u8_back.sv =====
// Back end of the transcoder: sends the head entry's bytes one per cycle
// while ready, via a registered output. Depends on u16u8_pkg, u16u8_if.
module u16u8_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  u16u8_pkg::entry_type pop_entry,
   u16u8_rsp_if.source          rsp_if
);

   logic                  rsp_valid_ff;
   logic [7:0]            out_byte_ff;
   logic                  run_last_ff;
   logic                  string_done_ff;
   u16u8_pkg::status_type status_ff;
   logic [1:0]            idx_ff, idx_in;
   logic                  advance;
   logic                  issue;
   logic                  last;

   assign advance = !rsp_valid_ff || rsp_if.ready;
   assign issue = advance && pop_valid;
   assign last = idx_ff == pop_entry.last_index;
   assign pop_ready = issue && last;
   assign idx_in = last ? 2'd0 : idx_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= pop_valid;
         end
         if (issue) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         out_byte_ff <= pop_entry.bytes[idx_ff];
         run_last_ff <= last;
         string_done_ff <= pop_entry.string_done;
         status_ff <= pop_entry.status;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.out_byte = out_byte_ff;
   assign rsp_if.run_last = run_last_ff;
   assign rsp_if.string_done = string_done_ff;
   assign rsp_if.status = status_ff;

endmodule

// ===== rtl/core/u16u8_checker.sv =====
// Assertions on the ports of the transcoder, and the bind that attaches
// them to the top level. Depends on u16u8_pkg, utf16_to_utf8_transcoder.
module u16u8_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [7:0]            rsp_out_byte,
   input logic                  rsp_run_last,
   input u16u8_pkg::status_type rsp_status
);

   // The cycle after reset shows no result item.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item valid right after reset");

   // An error item is a single zero byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != u16u8_pkg::STATUS_OK) |-> (rsp_run_last && rsp_out_byte == 8'd0))
      else $error("error item is not a single zero byte");

   // Bytes of one run follow each other without a gap and are continuation bytes.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_run_last) |=>
      (rsp_valid && rsp_out_byte[7:6] == 2'b10 && rsp_status == u16u8_pkg::STATUS_OK))
      else $error("run broken or byte is not a continuation byte");

   // A stalled result item holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_last)))
      else $error("stalled result item changed");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_out_byte (rsp_if.out_byte),
   .rsp_run_last (rsp_if.run_last),
   .rsp_status   (rsp_if.status)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for the UTF-16 to UTF-8 transcoder: a table of code units, then random strings
// checked byte by byte against a predictor with randomized gaps and stalls on both channels.
// Depends on u16u8_pkg, u16u8_if and utf16_to_utf8_transcoder.
module tb;

   localparam int NUM_DIRECTED = 24;
   localparam int NUM_RANDOM   = 146;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 150;

   typedef struct packed {
      logic [7:0]            out_byte;
      logic                  run_last;
      logic                  string_done;
      u16u8_pkg::status_type status;
   } utf8_byte_type;

   typedef utf8_byte_type [3:0] byte_run_type;

   typedef struct packed {
      logic [15:0]           unit;
      logic                  eos;
      logic                  typed;
      logic [2:0]            n;
      logic [31:0]           bytes;
      u16u8_pkg::status_type status;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   u16u8_req_if req_ch ();
   u16u8_rsp_if rsp_ch ();

   utf16_to_utf8_transcoder u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #4 clock = ~clock;

   utf8_byte_type expected_bytes[$];
   logic          lead_waiting = 1'b0;
   logic [9:0]    lead_low10 = '0;
   int            err_count = 0;
   int            idle_cycles = 0;
   int            flood_left = 0;
   bit            sender_burst = 1'b0;
   bit            receiver_burst = 1'b0;
   bit            hold_off_pending = 1'b0;

   stim_row_type directed_rows [0:NUM_DIRECTED-1] = '{
      '{16'h0000, 1'b0, 1'b1, 3'd1, 32'h00000000, u16u8_pkg::STATUS_OK},
      '{16'h007f, 1'b0, 1'b1, 3'd1, 32'h7f000000, u16u8_pkg::STATUS_OK},
      '{16'h0080, 1'b0, 1'b1, 3'd2, 32'hc2800000, u16u8_pkg::STATUS_OK},
      '{16'h07ff, 1'b0, 1'b1, 3'd2, 32'hdfbf0000, u16u8_pkg::STATUS_OK},
      '{16'h0800, 1'b0, 1'b1, 3'd3, 32'he0a08000, u16u8_pkg::STATUS_OK},
      '{16'hffff, 1'b1, 1'b1, 3'd3, 32'hefbfbf00, u16u8_pkg::STATUS_OK},
      '{16'hd800, 1'b0, 1'b1, 3'd0, 32'h00000000, u16u8_pkg::STATUS_OK},
      '{16'hdc00, 1'b0, 1'b1, 3'd4, 32'hf0908080, u16u8_pkg::STATUS_OK},
      '{16'hdbff, 1'b0, 1'b1, 3'd0, 32'h00000000, u16u8_pkg::STATUS_OK},
      '{16'hdfff, 1'b1, 1'b1, 3'd4, 32'hf48fbfbf, u16u8_pkg::STATUS_OK},
      '{16'hdc00, 1'b0, 1'b1, 3'd1, 32'h00000000, u16u8_pkg::STATUS_NO_LEAD},
      '{16'hd800, 1'b1, 1'b1, 3'd1, 32'h00000000, u16u8_pkg::STATUS_NO_TRAIL},
      '{16'hd801, 1'b0, 1'b1, 3'd0, 32'h00000000, u16u8_pkg::STATUS_OK},
      '{16'h0041, 1'b0, 1'b1, 3'd1, 32'h00000000, u16u8_pkg::STATUS_NO_TRAIL},
      '{16'hd802, 1'b0, 1'b1, 3'd0, 32'h00000000, u16u8_pkg::STATUS_OK},
      '{16'hd803, 1'b0, 1'b1, 3'd1, 32'h00000000, u16u8_pkg::STATUS_NO_TRAIL},
      '{16'hdc05, 1'b0, 1'b1, 3'd1, 32'h00000000, u16u8_pkg::STATUS_NO_LEAD},
      '{16'hdfff, 1'b1, 1'b1, 3'd1, 32'h00000000, u16u8_pkg::STATUS_NO_LEAD},
      '{16'hd7ff, 1'b0, 1'b0, 3'd0, 32'h00000000, u16u8_pkg::STATUS_OK},
      '{16'he000, 1'b0, 1'b0, 3'd0, 32'h00000000, u16u8_pkg::STATUS_OK},
      '{16'hd83d, 1'b0, 1'b0, 3'd0, 32'h00000000, u16u8_pkg::STATUS_OK},
      '{16'hde00, 1'b1, 1'b0, 3'd0, 32'h00000000, u16u8_pkg::STATUS_OK},
      '{16'h1234, 1'b0, 1'b0, 3'd0, 32'h00000000, u16u8_pkg::STATUS_OK},
      '{16'habcd, 1'b1, 1'b0, 3'd0, 32'h00000000, u16u8_pkg::STATUS_OK}
   };

   function automatic utf8_byte_type surrogate_error(input logic eos,
                                                     input u16u8_pkg::status_type status);
      return '{8'h00, 1'b1, eos, status};
   endfunction

   function automatic byte_run_type encode_utf8(input logic [20:0] cp, input logic eos,
                                                output int n);
      byte_run_type run;
      logic [7:0]   b [4];
      run = '0;
      if (cp < 21'h80) begin
         b[0] = cp[7:0];
         n = 1;
      end else if (cp < 21'h800) begin
         b[0] = {3'b110, cp[10:6]};
         b[1] = {2'b10, cp[5:0]};
         n = 2;
      end else if (cp < 21'h10000) begin
         b[0] = {4'b1110, cp[15:12]};
         b[1] = {2'b10, cp[11:6]};
         b[2] = {2'b10, cp[5:0]};
         n = 3;
      end else begin
         b[0] = {5'b11110, cp[20:18]};
         b[1] = {2'b10, cp[17:12]};
         b[2] = {2'b10, cp[11:6]};
         b[3] = {2'b10, cp[5:0]};
         n = 4;
      end
      for (int i = 0; i < n; i++) begin
         run[i] = '{b[i], (i == n - 1), eos, u16u8_pkg::STATUS_OK};
      end
      return run;
   endfunction

   function automatic byte_run_type transcode_unit(input logic [15:0] unit, input logic eos,
                                                   output int n);
      byte_run_type run;
      logic         is_lead;
      logic         is_trail;
      logic [20:0]  cp;
      run = '0;
      n = 0;
      is_lead = (unit & u16u8_pkg::SURROGATE_MASK) == u16u8_pkg::LEAD_TAG;
      is_trail = (unit & u16u8_pkg::SURROGATE_MASK) == u16u8_pkg::TRAIL_TAG;
      if (lead_waiting) begin
         lead_waiting = 1'b0;
         if (!is_trail) begin
            lead_low10 = '0;
            run[0] = surrogate_error(eos, u16u8_pkg::STATUS_NO_TRAIL);
            n = 1;
         end else begin
            cp = u16u8_pkg::PLANE1_BASE + {1'b0, lead_low10, unit[9:0]};
            lead_low10 = '0;
            run = encode_utf8(cp, eos, n);
         end
      end else if (is_lead) begin
         if (eos) begin
            run[0] = surrogate_error(eos, u16u8_pkg::STATUS_NO_TRAIL);
            n = 1;
         end else begin
            lead_waiting = 1'b1;
            lead_low10 = unit[9:0];
         end
      end else if (is_trail) begin
         run[0] = surrogate_error(eos, u16u8_pkg::STATUS_NO_LEAD);
         n = 1;
      end else begin
         run = encode_utf8({5'd0, unit}, eos, n);
      end
      return run;
   endfunction

   task automatic send_unit(input stim_row_type row);
      int           gap;
      int           n;
      byte_run_type run;
      if ($urandom_range(0, 15) == 0) sender_burst = !sender_burst;
      gap = (sender_burst || flood_left > 0) ? 0 : $urandom_range(0, 16);
      if (flood_left > 0) flood_left--;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.code_unit <= row.unit;
      req_ch.end_of_string <= row.eos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      run = transcode_unit(row.unit, row.eos, n);
      if (row.typed) begin
         n = int'(row.n);
         for (int i = 0; i < n; i++) begin
            run[i] = '{row.bytes[31 - 8 * i -: 8], (i == n - 1), row.eos, row.status};
         end
      end
      for (int i = 0; i < n; i++) expected_bytes = {expected_bytes, run[i]};
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      err_count++;
   endtask

   initial begin
      stim_row_type row;
      int           sent;
      int           pick;
      req_ch.valid = 1'b0;
      req_ch.code_unit = '0;
      req_ch.end_of_string = 1'b0;
      rsp_ch.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) send_unit(directed_rows[i]);
      sent = 0;
      while (sent < NUM_RANDOM) begin
         if (sent >= 40 && sent < 42 && flood_left == 0 && !hold_off_pending) begin
            hold_off_pending = 1'b1;
            flood_left = 30;
         end
         row = '0;
         row.eos = ($urandom_range(0, 7) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            row.unit = 16'($urandom_range(16'h0000, 16'h007f));
         end else if (pick < 50) begin
            row.unit = 16'($urandom_range(16'h0080, 16'h07ff));
         end else if (pick < 70) begin
            row.unit = $urandom_range(0, 1) ? 16'($urandom_range(16'h0800, 16'hd7ff))
                                            : 16'($urandom_range(16'he000, 16'hffff));
         end else if (pick < 90) begin
            row.unit = u16u8_pkg::LEAD_TAG | 16'($urandom_range(0, 1023));
            row.eos = 1'b0;
            send_unit(row);
            sent++;
            row.unit = u16u8_pkg::TRAIL_TAG | 16'($urandom_range(0, 1023));
            row.eos = ($urandom_range(0, 7) == 0);
         end else begin
            row.unit = 16'($urandom());
         end
         send_unit(row);
         sent++;
      end
      req_ch.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) receiver_burst = !receiver_burst;
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            stall = HOLD_CYCLES;
         end else begin
            stall = receiver_burst ? 0 : $urandom_range(0, 16);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      utf8_byte_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", rsp_ch.out_byte));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_ch.out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %02h, want %02h", rsp_ch.out_byte,
                                         want.out_byte));
            if (rsp_ch.run_last !== want.run_last)
               report_mismatch($sformatf("run_last %b, want %b", rsp_ch.run_last,
                                         want.run_last));
            if (rsp_ch.string_done !== want.string_done)
               report_mismatch($sformatf("string_done %b, want %b", rsp_ch.string_done,
                                         want.string_done));
            if (rsp_ch.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_ch.status,
                                         want.status));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
